// File: design/rsrp_pkg.sv
// Package for the row segment rechunk planner.
// Holds widths, register indexes, control structs and the segment end helper.
// Used by every module of the block; depends on nothing.
package rsrp_pkg;

  localparam int unsigned ColW     = 17;
  localparam int unsigned SumW     = 18;
  localparam int unsigned RowW     = 16;
  localparam int unsigned PageW    = 32;
  localparam int unsigned OffW     = 19;
  localparam int unsigned BytesW   = 20;
  localparam int unsigned EbW      = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam int unsigned DefMaxSegments = 64;
  localparam int unsigned DefMaxRowElems = 65536;

  localparam logic [ColW-1:0] SizeMax = ColW'(65536);

  localparam logic [CfgIdxW-1:0] RegInPage   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOutPage  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInSub    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutSub   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRowElems = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPagesRow = 3'd5;
  localparam logic [CfgIdxW-1:0] RegElemB    = 3'd6;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_end;
  } ctrl_status_t;

  // Last column of a segment that starts at s, bounded by the subblock size,
  // the elements left in the current page and the row end.
  function automatic logic [ColW-1:0] seg_end(input logic [ColW-1:0] s,
                                              input logic [ColW-1:0] left,
                                              input logic [ColW-1:0] sub,
                                              input logic [ColW-1:0] re);
    logic [SumW-1:0] a;
    logic [SumW-1:0] c;
    logic [SumW-1:0] m;
    a = SumW'(s) + SumW'(sub) - SumW'(1);
    c = SumW'(s) + SumW'(left) - SumW'(1);
    m = SumW'(re) - SumW'(1);
    if (a < m) m = a;
    if (c < m) m = c;
    return m[ColW-1:0];
  endfunction

endpackage

// File: design/rsrp_ctrl.sv
// Controller of the row segment rechunk planner.
// Sequences row load, setup and one segment step per cycle while the output is not stalled; uses rsrp_pkg.
module rsrp_ctrl #(
  parameter int unsigned MAX_SEGMENTS = rsrp_pkg::DefMaxSegments
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rsrp_pkg::ctrl_status_t status_i,
  output rsrp_pkg::ctrl_cmd_t    cmd_o,
  output logic                  seg_last_o,
  output logic                  seg_ovf_o
);

  localparam int unsigned CntW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_SEGMENTS - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            step;
  logic            cap;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign step        = (state_q == StRun) && (!ovalid_q || out_ready_i);
  assign cap         = (cnt_q == CntLast);
  assign seg_last_o  = status_i.row_end || cap;
  assign seg_ovf_o   = cap && !status_i.row_end;

  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.init = (state_q == StSetup);
  assign cmd_o.step = step;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        cnt_d   = '0;
        state_d = StRun;
      end
      StRun: begin
        if (step) begin
          ovalid_d = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
          if (seg_last_o) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// File: design/rsrp_dp.sv
// Datapath of the row segment rechunk planner.
// Holds configuration, walk position and the output beat register; uses rsrp_pkg.
module rsrp_dp #(
  parameter int unsigned MAX_ROW_ELEMS = rsrp_pkg::DefMaxRowElems
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsrp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rsrp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [rsrp_pkg::RowW-1:0]         row_index_i,
  input  rsrp_pkg::ctrl_cmd_t                cmd_i,
  input  logic                              seg_last_i,
  input  logic                              seg_ovf_i,
  output rsrp_pkg::ctrl_status_t             status_o,
  output logic                              do_read_o,
  output logic [rsrp_pkg::PageW-1:0]        read_page_o,
  output logic [rsrp_pkg::OffW-1:0]         read_offset_o,
  output logic [rsrp_pkg::BytesW-1:0]       read_bytes_o,
  output logic [rsrp_pkg::OffW-1:0]         copy_dst_offset_o,
  output logic [rsrp_pkg::OffW-1:0]         copy_src_offset_o,
  output logic [rsrp_pkg::BytesW-1:0]       copy_bytes_o,
  output logic                              claim_slot_o,
  output logic                              slot_done_o,
  output logic                              overflow_o,
  output logic                              last_o
);

  localparam int unsigned CW = rsrp_pkg::ColW;
  localparam int unsigned SW = rsrp_pkg::SumW;
  localparam int unsigned ReLim = (MAX_ROW_ELEMS < 65536) ? MAX_ROW_ELEMS : 65536;
  localparam logic [CW-1:0] ReMax = CW'(ReLim);

  logic [CW-1:0] in_page_q, out_page_q, in_sub_q, out_sub_q, row_el_q, ppr_q;
  logic [rsrp_pkg::EbW-1:0] eb_q;

  logic [CW-1:0] ip, op, isb, osb, re, ppr;
  logic [rsrp_pkg::EbW-1:0] eb;

  logic [rsrp_pkg::RowW-1:0]  row_q;
  logic [rsrp_pkg::PageW-1:0] base_q;
  logic [CW-1:0] is_q, ie_q, ipofs_q, ipage_q;
  logic [CW-1:0] os_q, oe_q, opofs_q;

  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v,
                                               input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) r = CW'(1);
    if (v > hi) r = hi;
    return r;
  endfunction

  always_comb begin
    ip  = clamp_size(in_page_q, rsrp_pkg::SizeMax);
    op  = clamp_size(out_page_q, rsrp_pkg::SizeMax);
    isb = clamp_size(in_sub_q, rsrp_pkg::SizeMax);
    osb = clamp_size(out_sub_q, rsrp_pkg::SizeMax);
    re  = clamp_size(row_el_q, ReMax);
    ppr = clamp_size(ppr_q, rsrp_pkg::SizeMax);
    eb  = eb_q;
    if (eb_q == '0) eb = rsrp_pkg::EbW'(1);
    if (eb_q > rsrp_pkg::EbW'(8)) eb = rsrp_pkg::EbW'(8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_page_q  <= CW'(64);
      out_page_q <= CW'(64);
      in_sub_q   <= CW'(32);
      out_sub_q  <= CW'(32);
      row_el_q   <= CW'(64);
      ppr_q      <= CW'(1);
      eb_q       <= rsrp_pkg::EbW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rsrp_pkg::RegInPage:   in_page_q  <= cfg_data_i;
        rsrp_pkg::RegOutPage:  out_page_q <= cfg_data_i;
        rsrp_pkg::RegInSub:    in_sub_q   <= cfg_data_i;
        rsrp_pkg::RegOutSub:   out_sub_q  <= cfg_data_i;
        rsrp_pkg::RegRowElems: row_el_q   <= cfg_data_i;
        rsrp_pkg::RegPagesRow: ppr_q      <= cfg_data_i;
        rsrp_pkg::RegElemB:    eb_q       <= cfg_data_i[rsrp_pkg::EbW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step decode for the current segment.
  logic          rd, over, claim, adv_in;
  logic [CW-1:0] end_c, start_c, in_len, copy_len;
  logic [SW-1:0] ip2, op2;
  logic          iwrap, owrap;
  logic [CW-1:0] is_n, ie_n, ipofs_n, ipage_n, os_n, oe_n, opofs_n;
  logic [CW-1:0] ileft, oleft, is_after;
  logic [rsrp_pkg::PageW-1:0] prod;

  always_comb begin
    rd       = (is_q >= os_q);
    over     = (ie_q >= oe_q);
    claim    = (os_q >= is_q);
    adv_in   = !over || (ie_q == oe_q);
    end_c    = over ? oe_q : ie_q;
    start_c  = claim ? os_q : is_q;
    copy_len = end_c - start_c + CW'(1);
    in_len   = ie_q - is_q + CW'(1);

    ip2   = SW'(ipofs_q) + SW'(in_len);
    iwrap = (ip2 == SW'(ip));
    is_n    = ie_q + CW'(1);
    ipofs_n = iwrap ? '0 : ip2[CW-1:0];
    ipage_n = ipage_q + CW'(iwrap);
    ileft   = ip - ipofs_n;
    ie_n    = rsrp_pkg::seg_end(is_n, ileft, isb, re);

    op2   = SW'(opofs_q) + SW'(oe_q - os_q + CW'(1));
    owrap = (op2 == SW'(op));
    os_n    = oe_q + CW'(1);
    opofs_n = owrap ? '0 : op2[CW-1:0];
    oleft   = op - opofs_n;
    oe_n    = rsrp_pkg::seg_end(os_n, oleft, osb, re);

    is_after = adv_in ? is_n : is_q;
    status_o.row_end = (is_after >= re);
    prod = rsrp_pkg::PageW'(row_q) * rsrp_pkg::PageW'(ppr);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= row_index_i;
    end
    if (cmd_i.init) begin
      base_q  <= prod;
      is_q    <= '0;
      ipofs_q <= '0;
      ipage_q <= '0;
      ie_q    <= rsrp_pkg::seg_end('0, ip, isb, re);
      os_q    <= '0;
      opofs_q <= '0;
      oe_q    <= rsrp_pkg::seg_end('0, op, osb, re);
    end else if (cmd_i.step) begin
      if (adv_in) begin
        is_q    <= is_n;
        ie_q    <= ie_n;
        ipofs_q <= ipofs_n;
        ipage_q <= ipage_n;
      end
      if (over) begin
        os_q    <= os_n;
        oe_q    <= oe_n;
        opofs_q <= opofs_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      do_read_o         <= rd;
      read_page_o       <= rd ? (base_q + rsrp_pkg::PageW'(ipage_q)) : '0;
      read_offset_o     <= rd ? rsrp_pkg::OffW'(ipofs_q) * rsrp_pkg::OffW'(eb) : '0;
      read_bytes_o      <= rd ? rsrp_pkg::BytesW'(in_len) * rsrp_pkg::BytesW'(eb) : '0;
      copy_bytes_o      <= rsrp_pkg::BytesW'(copy_len) * rsrp_pkg::BytesW'(eb);
      copy_src_offset_o <= claim ? rsrp_pkg::OffW'(os_q - is_q) * rsrp_pkg::OffW'(eb)
                                 : '0;
      copy_dst_offset_o <= claim ? '0
                                 : rsrp_pkg::OffW'(is_q - os_q) * rsrp_pkg::OffW'(eb);
      claim_slot_o      <= claim;
      slot_done_o       <= over;
      overflow_o        <= seg_ovf_i;
      last_o            <= seg_last_i;
    end
  end

endmodule

// File: design/row_segment_rechunk_planner_unit.sv
// Row segment rechunk planner: one row index in, up to MAX_SEGMENTS command beats out.
// After row accept, the setup state runs, then the run state registers the first beat.
// Throughput: one command beat per cycle while out_ready_i is high, set by the segment
// walk step; the next row is accepted only after the step that yields a row's last command.
// Reset: asynchronous active low; clears control state and loads register defaults.
module row_segment_rechunk_planner_unit #(
  parameter int unsigned MAX_SEGMENTS  = rsrp_pkg::DefMaxSegments,
  parameter int unsigned MAX_ROW_ELEMS = rsrp_pkg::DefMaxRowElems
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsrp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rsrp_pkg::RowW-1:0]     row_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          do_read_o,
  output logic [rsrp_pkg::PageW-1:0]    read_page_o,
  output logic [rsrp_pkg::OffW-1:0]     read_offset_o,
  output logic [rsrp_pkg::BytesW-1:0]   read_bytes_o,
  output logic [rsrp_pkg::OffW-1:0]     copy_dst_offset_o,
  output logic [rsrp_pkg::OffW-1:0]     copy_src_offset_o,
  output logic [rsrp_pkg::BytesW-1:0]   copy_bytes_o,
  output logic                          claim_slot_o,
  output logic                          slot_done_o,
  output logic                          overflow_o,
  output logic                          last_o
);

  rsrp_pkg::ctrl_cmd_t    cmd;
  rsrp_pkg::ctrl_status_t status;
  logic                   seg_last;
  logic                   seg_ovf;

  assign cfg_ready_o = 1'b1;

  rsrp_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .seg_last_o (seg_last),
    .seg_ovf_o  (seg_ovf)
  );

  rsrp_dp #(
    .MAX_ROW_ELEMS(MAX_ROW_ELEMS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .row_index_i      (row_index_i),
    .cmd_i            (cmd),
    .seg_last_i       (seg_last),
    .seg_ovf_i        (seg_ovf),
    .status_o         (status),
    .do_read_o        (do_read_o),
    .read_page_o      (read_page_o),
    .read_offset_o    (read_offset_o),
    .read_bytes_o     (read_bytes_o),
    .copy_dst_offset_o(copy_dst_offset_o),
    .copy_src_offset_o(copy_src_offset_o),
    .copy_bytes_o     (copy_bytes_o),
    .claim_slot_o     (claim_slot_o),
    .slot_done_o      (slot_done_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

endmodule

// File: design/rsrp_checker.sv
// Port-level checker for the row segment rechunk planner, bound to the top level.
// Depends on rsrp_pkg for widths.
module rsrp_port_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic overflow_o,
  input logic last_o,
  input logic [rsrp_pkg::BytesW-1:0] copy_bytes_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_o)
    else $error("Overflow beat is not the last beat of its row.");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A row was accepted while another row was being planned.");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> copy_bytes_o != '0)
    else $error("Command beat copies no bytes.");

endmodule

bind row_segment_rechunk_planner_unit rsrp_port_props u_rsrp_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .overflow_o  (overflow_o),
  .last_o      (last_o),
  .copy_bytes_o(copy_bytes_o)
);
